FILE: hw/rtl/isp_pkg.sv
`default_nettype none

package isp_pkg;

   // Field widths of the request and response beats
   localparam int OP_W      = 3;
   localparam int CH_W      = 3;
   localparam int TMO_W     = 24;
   localparam int DUR_W     = 18;
   localparam int SHIFT_W   = 3;
   localparam int BITMAP_W  = 8;
   localparam int MODE_W    = 2;
   localparam int CNT_OUT_W = 16;

   // Defaults for the top-level parameters
   localparam int CHANNELS_DEF     = 8;
   localparam int COUNTER_BITS_DEF = 16;

   // Operation codes
   localparam logic [OP_W-1:0] OP_TICK     = 3'd0;
   localparam logic [OP_W-1:0] OP_ARM      = 3'd1;
   localparam logic [OP_W-1:0] OP_ARM_NEXT = 3'd2;
   localparam logic [OP_W-1:0] OP_CANCEL   = 3'd3;
   localparam logic [OP_W-1:0] OP_CLEAR    = 3'd4;

   // Channel modes
   localparam logic [MODE_W-1:0] MODE_OFF     = 2'd0;
   localparam logic [MODE_W-1:0] MODE_PENDING = 2'd1;
   localparam logic [MODE_W-1:0] MODE_RUNNING = 2'd2;

   // Configuration registers
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 24;
   localparam logic [CSR_IDX_W-1:0] CSR_SHIFT   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_TMO = 1'd1;
   localparam logic [SHIFT_W-1:0]   SHIFT_RST   = 3'd2;
   localparam logic [TMO_W-1:0]     MAX_TMO_RST = 24'd262140;

   typedef struct packed {
      logic [OP_W-1:0]  operation;
      logic [CH_W-1:0]  channel;
      logic [TMO_W-1:0] timeout_us;
      logic [DUR_W-1:0] duration_us;
   } req_type;

   typedef struct packed {
      logic [BITMAP_W-1:0]  pulses_active;
      logic [BITMAP_W-1:0]  pulse_starts;
      logic [BITMAP_W-1:0]  pulse_ends;
      logic [MODE_W-1:0]    channel_state;
      logic                 channel_queued;
      logic [CNT_OUT_W-1:0] counter_now;
   } rsp_type;

   // Per-channel strobes, already qualified by the stage advance
   typedef struct packed {
      logic tick;
      logic arm;
      logic arm_next;
      logic cancel;
      logic clear;
   } chan_cmd_type;

   // Per-channel status after the item
   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic              queued;
      logic              started;
      logic              ended;
   } chan_stat_type;

endpackage

`default_nettype wire

FILE: hw/rtl/isp_if.sv
`default_nettype none

interface isp_req_if;
   import isp_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface isp_rsp_if;
   import isp_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/isp_channel.sv
`default_nettype none

module isp_channel #(
   parameter int COUNTER_BITS = isp_pkg::COUNTER_BITS_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire isp_pkg::chan_cmd_type       cmd,
   input  wire logic [isp_pkg::SHIFT_W-1:0] shift,
   input  wire logic [COUNTER_BITS-1:0]     counter_next,
   input  wire logic [COUNTER_BITS-1:0]     arm_target,
   input  wire logic [COUNTER_BITS-1:0]     queue_target,
   input  wire logic [isp_pkg::DUR_W-1:0]   duration_us,
   output isp_pkg::chan_stat_type           status
);
   import isp_pkg::*;

   localparam int WIDE_W = (COUNTER_BITS > DUR_W) ? COUNTER_BITS : DUR_W;

   logic [MODE_W-1:0]       mode_ff, mode_in;
   logic                    enabled_ff, enabled_in;
   logic                    queued_ff, queued_in;
   logic [COUNTER_BITS-1:0] compare_ff, compare_in;
   logic [COUNTER_BITS-1:0] qstart_ff, qstart_in;
   logic [DUR_W-1:0]        width_ff, width_in;
   logic [WIDE_W-1:0]       width_ticks;
   logic                    started, ended;

   assign width_ticks = WIDE_W'(width_ff) >> shift;

   always_comb begin
      mode_in    = mode_ff;
      enabled_in = enabled_ff;
      queued_in  = queued_ff;
      compare_in = compare_ff;
      qstart_in  = qstart_ff;
      width_in   = width_ff;
      started    = 1'b0;
      ended      = 1'b0;
      if (cmd.tick) begin
         if (enabled_ff && (compare_ff == counter_next)) begin
            case (mode_ff)
               MODE_PENDING: begin
                  mode_in    = MODE_RUNNING;
                  compare_in = counter_next + width_ticks[COUNTER_BITS-1:0];
                  started    = 1'b1;
               end
               MODE_RUNNING: begin
                  ended = 1'b1;
                  if (queued_ff) begin
                     // load the queued schedule
                     compare_in = qstart_ff;
                     mode_in    = MODE_PENDING;
                     queued_in  = 1'b0;
                  end else begin
                     mode_in    = MODE_OFF;
                     enabled_in = 1'b0;
                  end
               end
               default: begin
                  mode_in    = MODE_OFF;
                  enabled_in = 1'b0;
               end
            endcase
         end
      end else if (cmd.arm) begin
         width_in   = duration_us;
         compare_in = arm_target;
         mode_in    = MODE_PENDING;
         enabled_in = 1'b1;
      end else if (cmd.arm_next) begin
         qstart_in = queue_target;
         queued_in = 1'b1;
      end else if (cmd.cancel) begin
         if (mode_ff == MODE_PENDING) begin
            mode_in = MODE_OFF;
         end
      end else if (cmd.clear) begin
         mode_in    = MODE_OFF;
         enabled_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_OFF;
         enabled_ff <= 1'b0;
         queued_ff  <= 1'b0;
      end else begin
         mode_ff    <= mode_in;
         enabled_ff <= enabled_in;
         queued_ff  <= queued_in;
      end
   end

   always_ff @(posedge clock) begin
      compare_ff <= compare_in;
      qstart_ff  <= qstart_in;
      width_ff   <= width_in;
   end

   assign status.mode    = mode_in;
   assign status.queued  = queued_in;
   assign status.started = started;
   assign status.ended   = ended;

endmodule

`default_nettype wire

FILE: hw/rtl/injector_pulse_scheduler.sv
// Channel    Dir  Beat                                        Accepted when
// req_chan   in   operation, channel, timeout_us, duration_us valid && ready
// rsp_chan   out  bitmaps, channel_state/queued, counter_now  valid && ready
// csr_*      in   csr_index, csr_wdata                        csr_we
//
// One beat per clock while the response is not stalled: a request beat lands in the
// input register, and as it advances all channels compare and update in parallel
// into the result register, from which the response is driven. The per-channel
// add-and-compare sets the cycle time. Reset clears the counter, every channel,
// queue flags and both valids; configuration returns to shift 2, max timeout 262140.
// A stalled response holds the result register; one more beat fills the input
// register, then ready stays low until the result leaves.
`default_nettype none

module injector_pulse_scheduler #(
   parameter int CHANNELS     = isp_pkg::CHANNELS_DEF,
   parameter int COUNTER_BITS = isp_pkg::COUNTER_BITS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   isp_req_if.sink                             req_chan,
   isp_rsp_if.source                           rsp_chan,
   input  wire logic                           csr_we,
   input  wire logic [isp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [isp_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import isp_pkg::*;

   localparam int WIDE_W = (COUNTER_BITS > TMO_W) ? COUNTER_BITS : TMO_W;

   // configuration
   logic [SHIFT_W-1:0] shift_ff, shift_in;
   logic [TMO_W-1:0]   max_tmo_ff, max_tmo_in;

   // input register and result register
   logic    s1_valid_ff, s1_valid_in;
   req_type s1_ff, s1_in;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic [COUNTER_BITS-1:0] counter_ff, counter_in;
   logic [COUNTER_BITS-1:0] counter_next;

   logic req_take, advance, chan_ok, is_tick;
   logic [TMO_W-1:0]        tmo_clamped;
   logic [WIDE_W-1:0]       arm_ticks, queue_ticks;
   logic [COUNTER_BITS-1:0] arm_target, queue_target;

   chan_cmd_type  cmd    [CHANNELS];
   chan_stat_type status [CHANNELS];

   logic [BITMAP_W-1:0] active_map, start_map, end_map;
   logic [MODE_W-1:0]   sel_mode;
   logic                sel_queued;

   // ---------------------------------------------------------------------
   // Handshake: advance the input register whenever the result register
   // is free or its beat leaves this cycle
   // ---------------------------------------------------------------------
   assign advance        = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_in       = s1_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
         s1_in       = req_chan.data;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   // ---------------------------------------------------------------------
   // Configuration writes
   // ---------------------------------------------------------------------
   always_comb begin
      shift_in   = shift_ff;
      max_tmo_in = max_tmo_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_SHIFT:   shift_in   = csr_wdata[SHIFT_W-1:0];
            CSR_MAX_TMO: max_tmo_in = csr_wdata[TMO_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Shared arithmetic: counter step, timeout clamp and tick conversion
   // ---------------------------------------------------------------------
   assign is_tick      = (s1_ff.operation == OP_TICK);
   assign chan_ok      = int'(s1_ff.channel) < CHANNELS;
   assign counter_next = counter_ff + COUNTER_BITS'(1);
   assign counter_in   = (advance && is_tick) ? counter_next : counter_ff;

   // a timeout beyond the limit becomes limit minus one, wrapping in 24 bits
   assign tmo_clamped  = (s1_ff.timeout_us > max_tmo_ff) ? (max_tmo_ff - TMO_W'(1))
                                                        : s1_ff.timeout_us;
   assign arm_ticks    = WIDE_W'(tmo_clamped) >> shift_ff;
   assign queue_ticks  = WIDE_W'(s1_ff.timeout_us) >> shift_ff;
   assign arm_target   = counter_ff + arm_ticks[COUNTER_BITS-1:0];
   assign queue_target = counter_ff + queue_ticks[COUNTER_BITS-1:0];

   // ---------------------------------------------------------------------
   // Channel cells: broadcast the tick and decode the addressed operation into strobes
   // ---------------------------------------------------------------------
   for (genvar i = 0; i < CHANNELS; i++) begin : g_chan
      logic hit;
      assign hit = advance && chan_ok && (int'(s1_ff.channel) == i);

      assign cmd[i].tick     = advance && is_tick;
      assign cmd[i].arm      = hit && (s1_ff.operation == OP_ARM);
      assign cmd[i].arm_next = hit && (s1_ff.operation == OP_ARM_NEXT);
      assign cmd[i].cancel   = hit && (s1_ff.operation == OP_CANCEL);
      assign cmd[i].clear    = hit && (s1_ff.operation == OP_CLEAR);

      isp_channel #(
         .COUNTER_BITS (COUNTER_BITS)
      ) u_channel (
         .clock        (clock),
         .reset        (reset),
         .cmd          (cmd[i]),
         .shift        (shift_ff),
         .counter_next (counter_next),
         .arm_target   (arm_target),
         .queue_target (queue_target),
         .duration_us  (s1_ff.duration_us),
         .status       (status[i])
      );
   end

   // bitmaps carry only the first eight channels
   for (genvar j = 0; j < BITMAP_W; j++) begin : g_map
      if (j < CHANNELS) begin : g_live
         assign active_map[j] = (status[j].mode == MODE_RUNNING);
         assign start_map[j]  = status[j].started;
         assign end_map[j]    = status[j].ended;
      end else begin : g_none
         assign active_map[j] = 1'b0;
         assign start_map[j]  = 1'b0;
         assign end_map[j]    = 1'b0;
      end
   end

   // addressed channel status; an absent channel reads as off, not queued
   always_comb begin
      sel_mode   = MODE_OFF;
      sel_queued = 1'b0;
      for (int k = 0; k < CHANNELS; k++) begin
         if (int'(s1_ff.channel) == k) begin
            sel_mode   = status[k].mode;
            sel_queued = status[k].queued;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result register
   // ---------------------------------------------------------------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (advance) begin
         rsp_valid_in          = 1'b1;
         rsp_in.pulses_active  = active_map;
         rsp_in.pulse_starts   = start_map;
         rsp_in.pulse_ends     = end_map;
         rsp_in.channel_state  = sel_mode;
         rsp_in.channel_queued = sel_queued;
         rsp_in.counter_now    = CNT_OUT_W'(counter_in);
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         counter_ff   <= '0;
         shift_ff     <= SHIFT_RST;
         max_tmo_ff   <= MAX_TMO_RST;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         counter_ff   <= counter_in;
         shift_ff     <= shift_in;
         max_tmo_ff   <= max_tmo_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff  <= s1_in;
      rsp_ff <= rsp_in;
   end

   // ---------------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------------
   a_tick_steps_counter: assert property (@(posedge clock) disable iff (reset)
      (advance && is_tick) |=> (counter_ff == $past(counter_next)))
      else $error("tick did not step the counter by one");

   a_counter_holds: assert property (@(posedge clock) disable iff (reset)
      !(advance && is_tick) |=> $stable(counter_ff))
      else $error("counter moved without a tick");

   a_no_edges_off_tick: assert property (@(posedge clock) disable iff (reset)
      (advance && !is_tick) |=> (rsp_ff.pulse_starts == '0 && rsp_ff.pulse_ends == '0))
      else $error("pulse edge reported on a non-tick beat");

   a_start_is_active: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_ff.pulse_starts & ~rsp_ff.pulses_active) == '0))
      else $error("started channel not running");

   a_end_not_active: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_ff.pulse_ends & rsp_ff.pulses_active) == '0))
      else $error("ended channel still running");

endmodule

`default_nettype wire
